// File: design/bts_pkg.sv
package bts_pkg;

   // Pixel and configuration widths.
   localparam int PIX_W        = 8;
   localparam int WIDTH_REG_W  = 11;
   localparam int HEIGHT_REG_W = 13;
   localparam int CFG_W        = 13;
   localparam int ROW_W        = 13;
   localparam int CSR_IDX_W    = 1;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT = 1'b1;

   // Reset values of the frame size registers.
   localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd640;
   localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd480;

   // Operation codes of an input word.
   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   // Smallest frame dimension and the border that is forced to zero.
   localparam int MIN_DIM     = 5;
   localparam int EDGE_MARGIN = 2;

   // Templates, tried in order. The first N_SET_ONE force a one, the rest a zero.
   // Flag bits: 0 TL, 1 T, 2 TR, 3 L, 4 R, 5 BL, 6 B, 7 BR.
   localparam int N_TPL     = 13;
   localparam int N_SET_ONE = 5;
   localparam logic [7:0] TPL_CARE [N_TPL] = '{
      8'h5A, 8'hFA, 8'hDE, 8'h5F, 8'h7B,
      8'hFB, 8'hFE, 8'hDF, 8'h7F,
      8'h7F, 8'hFB, 8'hFE, 8'hDF
   };
   localparam logic [7:0] TPL_WANT [N_TPL] = '{
      8'h5A, 8'h9A, 8'h4E, 8'h59, 8'h72,
      8'h90, 8'h06, 8'h09, 8'h60,
      8'h10, 8'h02, 8'h08, 8'h40
   };

   typedef logic [PIX_W-1:0] pixel_type;

   // What the sequencer decided for one accepted word.
   typedef struct packed {
      logic pixel;      // word carries a pixel: update line stores and window
      logic result;     // word gives a result
      logic edge_zero;  // result is forced to zero
      logic frame_end;  // result is the last of the frame
   } bts_ctl_type;

endpackage

// File: design/bts_line_mem.sv
module bts_line_mem #(
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output bts_pkg::pixel_type       rd_data,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  bts_pkg::pixel_type       wr_data
);
   import bts_pkg::*;

   pixel_type mem [DEPTH];
   pixel_type rd_data_ff;

   // Synchronous write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Synchronous read port; the data holds until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/bts_ctrl.sv
module bts_ctrl #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   input  logic [bts_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [bts_pkg::CFG_W-1:0]           csr_wdata,
   input  logic                                req_fire,
   input  logic                                req_op,
   output bts_pkg::bts_ctl_type                ctl,
   output logic [$clog2(MAX_WIDTH)-1:0]        col_addr
);
   import bts_pkg::*;

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int WID_W  = $clog2(MAX_WIDTH + 1);
   localparam int PEND_W = $clog2(MAX_WIDTH + 2);
   localparam int CMP_W  = ((WID_W > WIDTH_REG_W) ? WID_W : WIDTH_REG_W) + 1;
   localparam int EW     = WID_W + 1;
   localparam int RW     = ROW_W + 1;

   logic [WIDTH_REG_W-1:0]  width_ff, width_in;
   logic [HEIGHT_REG_W-1:0] height_ff, height_in;
   logic [ROW_W-1:0]        in_row_ff, in_row_in;
   logic [COL_W-1:0]        in_col_ff, in_col_in;
   logic [ROW_W-1:0]        out_row_ff, out_row_in;
   logic [COL_W-1:0]        out_col_ff, out_col_in;
   logic [PEND_W-1:0]       pend_ff, pend_in;

   logic [CMP_W-1:0]        width_ext;
   logic [WID_W-1:0]        w_eff;
   logic [ROW_W-1:0]        h_eff;
   logic [WID_W-1:0]        in_col_nx;
   logic [WID_W-1:0]        out_col_nx;
   logic                    input_done;
   logic                    at_edge;
   logic                    pend_full;
   logic                    pend_last;

   // Effective frame size: width saturated into the line store range, height at least MIN_DIM.
   always_comb begin
      width_ext = CMP_W'(width_ff);
      if (width_ext < CMP_W'(MIN_DIM)) begin
         w_eff = WID_W'(MIN_DIM);
      end else if (width_ext > CMP_W'(MAX_WIDTH)) begin
         w_eff = WID_W'(MAX_WIDTH);
      end else begin
         w_eff = WID_W'(width_ext);
      end
      if (height_ff < ROW_W'(MIN_DIM)) begin
         h_eff = ROW_W'(MIN_DIM);
      end else begin
         h_eff = height_ff;
      end
   end

   // Status derived from the counters.
   assign input_done = in_row_ff >= h_eff;
   assign in_col_nx  = WID_W'(in_col_ff) + WID_W'(1);
   assign out_col_nx = WID_W'(out_col_ff) + WID_W'(1);
   assign pend_full  = pend_ff >= (PEND_W'(w_eff) + PEND_W'(1));
   assign pend_last  = pend_ff == PEND_W'(1);
   assign at_edge    = (out_row_ff < ROW_W'(EDGE_MARGIN))
                    || ((RW'(out_row_ff) + RW'(EDGE_MARGIN)) >= RW'(h_eff))
                    || (out_col_ff < COL_W'(EDGE_MARGIN))
                    || ((EW'(out_col_ff) + EW'(EDGE_MARGIN)) >= EW'(w_eff));

   assign col_addr = in_col_ff;

   // Decision for the word on the input channel, and the counter updates it causes.
   always_comb begin
      ctl        = '0;
      width_in   = width_ff;
      height_in  = height_ff;
      in_row_in  = in_row_ff;
      in_col_in  = in_col_ff;
      out_row_in = out_row_ff;
      out_col_in = out_col_ff;
      pend_in    = pend_ff;

      if (csr_valid) begin
         case (csr_index)
            CSR_WIDTH: begin
               width_in = csr_wdata[WIDTH_REG_W-1:0];
            end
            CSR_HEIGHT: begin
               height_in = csr_wdata[HEIGHT_REG_W-1:0];
            end
            default: begin
            end
         endcase
      end

      if (req_fire) begin
         if (req_op == OP_DRAIN) begin
            // A drain tick only counts once the whole frame is in and something is owed.
            if (input_done && (pend_ff != '0)) begin
               ctl.result    = 1'b1;
               ctl.edge_zero = 1'b1;
               ctl.frame_end = pend_last;
               pend_in       = pend_ff - PEND_W'(1);
               if (out_col_nx >= w_eff) begin
                  out_col_in = '0;
                  out_row_in = out_row_ff + ROW_W'(1);
               end else begin
                  out_col_in = COL_W'(out_col_nx);
               end
               if (pend_last) begin
                  in_row_in  = '0;
                  in_col_in  = '0;
                  out_row_in = '0;
                  out_col_in = '0;
               end
            end
         end else if (!input_done) begin
            ctl.pixel = 1'b1;
            if (pend_full) begin
               ctl.result    = 1'b1;
               ctl.edge_zero = at_edge;
               if (out_col_nx >= w_eff) begin
                  out_col_in = '0;
                  out_row_in = out_row_ff + ROW_W'(1);
               end else begin
                  out_col_in = COL_W'(out_col_nx);
               end
            end else begin
               pend_in = pend_ff + PEND_W'(1);
            end
            if (in_col_nx >= w_eff) begin
               in_col_in = '0;
               in_row_in = in_row_ff + ROW_W'(1);
            end else begin
               in_col_in = COL_W'(in_col_nx);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= WIDTH_RESET;
         height_ff  <= HEIGHT_RESET;
         in_row_ff  <= '0;
         in_col_ff  <= '0;
         out_row_ff <= '0;
         out_col_ff <= '0;
         pend_ff    <= '0;
      end else begin
         width_ff   <= width_in;
         height_ff  <= height_in;
         in_row_ff  <= in_row_in;
         in_col_ff  <= in_col_in;
         out_row_ff <= out_row_in;
         out_col_ff <= out_col_in;
         pend_ff    <= pend_in;
      end
   end

endmodule

// File: design/bts_window.sv
module bts_window (
   input  logic               clock,
   input  logic               reset,
   input  logic               shift,
   input  bts_pkg::pixel_type up_pixel,
   input  bts_pkg::pixel_type mid_pixel,
   input  bts_pkg::pixel_type new_pixel,
   output bts_pkg::pixel_type smooth_pixel
);
   import bts_pkg::*;

   // Two previous columns: 0..2 oldest (top, middle, bottom), 3..5 newer.
   pixel_type win_ff [6];
   pixel_type win_in [6];
   logic [7:0] flags;
   logic       found;

   // Neighbour flags, nonzero or zero.
   always_comb begin
      flags[0] = win_ff[0] != '0;
      flags[1] = win_ff[3] != '0;
      flags[2] = up_pixel  != '0;
      flags[3] = win_ff[1] != '0;
      flags[4] = mid_pixel != '0;
      flags[5] = win_ff[2] != '0;
      flags[6] = win_ff[5] != '0;
      flags[7] = new_pixel != '0;
   end

   // First matching template decides; with no match the centre byte is copied.
   always_comb begin
      found        = 1'b0;
      smooth_pixel = win_ff[4];
      for (int t = 0; t < N_TPL; t++) begin
         if (!found && ((flags & TPL_CARE[t]) == TPL_WANT[t])) begin
            found        = 1'b1;
            smooth_pixel = (t < N_SET_ONE) ? PIX_W'(1) : '0;
         end
      end
   end

   // Window shifts one column on every pixel word.
   always_comb begin
      win_in[0] = win_ff[3];
      win_in[1] = win_ff[4];
      win_in[2] = win_ff[5];
      win_in[3] = up_pixel;
      win_in[4] = mid_pixel;
      win_in[5] = new_pixel;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else if (shift) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= win_in[i];
         end
      end
   end

endmodule

// File: design/binary_template_smoother_3x3.sv
// A result passes the staging register, then the output register; the word that releases it
// is the pixel one row plus one pixel behind it, or a drain tick at the end of the frame.
// Throughput: one word per cycle unless output stalls, set by one read and write per store.
// Reset clears the counters, the window and all valid flags and loads a 640 x 480 frame size;
// the line stores are not cleared, since only forced-zero border results ever read stale rows.
module binary_template_smoother_3x3 #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_op,
   input  bts_pkg::pixel_type            req_pixel_value,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output bts_pkg::pixel_type            rsp_out_pixel,
   output logic                          rsp_frame_end,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [bts_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bts_pkg::CFG_W-1:0]     csr_wdata
);
   import bts_pkg::*;

   localparam int COL_W = $clog2(MAX_WIDTH);

   logic             req_fire;
   bts_ctl_type      ctl;
   logic [COL_W-1:0] col_addr;
   logic             rd_en;

   logic             s1_valid_ff, s1_valid_in;
   bts_ctl_type      s1_ctl_ff;
   logic [COL_W-1:0] s1_addr_ff;
   pixel_type        s1_px_ff;
   logic             s1_go;
   logic             wr_en;

   pixel_type        up_rd;
   pixel_type        mid_rd;
   pixel_type        smooth_pixel;

   logic             rsp_valid_ff, rsp_valid_in;
   pixel_type        rsp_pixel_ff;
   logic             rsp_frame_end_ff;
   logic             out_free;

   // Handshakes. A word is taken whenever the staging register is empty or moves on.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s1_go     = s1_valid_ff && (!s1_ctl_ff.result || out_free);
   assign req_ready = !s1_valid_ff || s1_go;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   bts_ctrl #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_fire  (req_fire),
      .req_op    (req_op),
      .ctl       (ctl),
      .col_addr  (col_addr)
   );

   // Line stores: read at accept, written back one stage later at the same column.
   // Consecutive pixels always sit in different columns, so a read never meets the
   // write of the same entry in one cycle.
   assign rd_en = req_fire && ctl.pixel;
   assign wr_en = s1_go && s1_ctl_ff.pixel;

   bts_line_mem #(
      .DEPTH (MAX_WIDTH)
   ) u_upper (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (col_addr),
      .rd_data (up_rd),
      .wr_en   (wr_en),
      .wr_addr (s1_addr_ff),
      .wr_data (mid_rd)
   );

   bts_line_mem #(
      .DEPTH (MAX_WIDTH)
   ) u_middle (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (col_addr),
      .rd_data (mid_rd),
      .wr_en   (wr_en),
      .wr_addr (s1_addr_ff),
      .wr_data (s1_px_ff)
   );

   bts_window u_window (
      .clock        (clock),
      .reset        (reset),
      .shift        (wr_en),
      .up_pixel     (up_rd),
      .mid_pixel    (mid_rd),
      .new_pixel    (s1_px_ff),
      .smooth_pixel (smooth_pixel)
   );

   // Staging register: holds a word while its line store data is read.
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (s1_go) begin
         s1_valid_in = 1'b0;
      end
      if (req_fire && (ctl.pixel || ctl.result)) begin
         s1_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_ctl_ff  <= ctl;
         s1_addr_ff <= col_addr;
         s1_px_ff   <= req_pixel_value;
      end
   end

   // Output register.
   assign rsp_valid_in = (s1_go && s1_ctl_ff.result) ? 1'b1 :
                         (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go && s1_ctl_ff.result) begin
         rsp_pixel_ff     <= s1_ctl_ff.edge_zero ? '0 : smooth_pixel;
         rsp_frame_end_ff <= s1_ctl_ff.frame_end;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_pixel = rsp_pixel_ff;
   assign rsp_frame_end = rsp_frame_end_ff;

   // A result leaving the staging register always lands in the output register.
   ap_result_lands: assert property (@(posedge clock) disable iff (reset)
      s1_go && s1_ctl_ff.result |=> rsp_valid_ff)
      else $error("result lost between staging and output register");

   // The end-of-frame word is a border result and therefore zero.
   ap_frame_end_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_frame_end_ff |-> rsp_pixel_ff == '0)
      else $error("frame end word carries a nonzero pixel");

   // Read and write-back of a line store never address the same column together.
   ap_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      rd_en && wr_en |-> col_addr != s1_addr_ff)
      else $error("line store read meets write-back of the same column");

   // A stalled staging word keeps its decision.
   ap_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_go |=> s1_valid_ff && $stable(s1_ctl_ff))
      else $error("stalled staging word changed");

endmodule

// File: test/smoother_checker.sv
module smoother_checker #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic                          req_op,
   input  bts_pkg::pixel_type            req_pixel_value,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  bts_pkg::pixel_type            rsp_out_pixel,
   input  logic                          rsp_frame_end,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [bts_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bts_pkg::CFG_W-1:0]     csr_wdata,
   output int                            mismatches,
   output int                            owed_count
);

   import bts_pkg::*;

   localparam int SIDE_MIN      = 5;
   localparam int BORDER        = 2;
   localparam int TEMPLATES     = 13;
   localparam int ONE_TEMPLATES = 5;

   // Template masks and patterns, last template first, so that template t sits at
   // bits 8t+7 down to 8t. Flag bits: 0 TL, 1 T, 2 TR, 3 L, 4 R, 5 BL, 6 B, 7 BR.
   localparam logic [TEMPLATES*8-1:0] HIT_MASK = {
      8'hDF, 8'hFE, 8'hFB, 8'h7F, 8'h7F, 8'hDF, 8'hFE, 8'hFB,
      8'h7B, 8'h5F, 8'hDE, 8'hFA, 8'h5A
   };
   localparam logic [TEMPLATES*8-1:0] HIT_PATTERN = {
      8'h40, 8'h08, 8'h02, 8'h10, 8'h60, 8'h09, 8'h06, 8'h90,
      8'h72, 8'h59, 8'h4E, 8'h9A, 8'h5A
   };

   typedef struct packed {
      pixel_type pixel;
      logic      frame_end;
   } smoothed_word_type;

   // Smoothed words still owed by the block, oldest first.
   smoothed_word_type owed_q [$];

   // Own copy of the frame size, the line stores, the window and the counters.
   logic [WIDTH_REG_W-1:0]  width_reg;
   logic [HEIGHT_REG_W-1:0] height_reg;
   pixel_type               upper_row [MAX_WIDTH];
   pixel_type               middle_row [MAX_WIDTH];
   pixel_type               past_cols [6];
   int                      in_row;
   int                      in_col;
   int                      out_row;
   int                      out_col;
   int                      held_back;

   task automatic report_fault(input string msg);
      $display("smoother_checker at %0t: %s", $time, msg);
      mismatches++;
   endtask

   function automatic int frame_width();
      int w;
      w = width_reg;
      if (w < SIDE_MIN) w = SIDE_MIN;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      return w;
   endfunction

   function automatic int frame_height();
      return (height_reg < SIDE_MIN) ? SIDE_MIN : int'(height_reg);
   endfunction

   function automatic bit near_border(input int row, input int col, input int w, input int h);
      return row < BORDER || row + BORDER >= h || col < BORDER || col + BORDER >= w;
   endfunction

   // The first matching template decides; with no match the centre byte passes through.
   function automatic pixel_type apply_templates(input logic [7:0] nb, input pixel_type centre);
      for (int t = 0; t < TEMPLATES; t++) begin
         if ((nb & HIT_MASK[t*8 +: 8]) == HIT_PATTERN[t*8 +: 8])
            return (t < ONE_TEMPLATES) ? 8'd1 : 8'd0;
      end
      return centre;
   endfunction

   task automatic clear_model();
      width_reg  = 11'd640;
      height_reg = 13'd480;
      for (int i = 0; i < MAX_WIDTH; i++) begin
         upper_row[i]  = '0;
         middle_row[i] = '0;
      end
      for (int i = 0; i < 6; i++) past_cols[i] = '0;
      in_row    = 0;
      in_col    = 0;
      out_row   = 0;
      out_col   = 0;
      held_back = 0;
      owed_q.delete();
   endtask

   task automatic advance_out(input int w);
      out_col++;
      if (out_col >= w) begin
         out_col = 0;
         out_row++;
      end
   endtask

   // Works out what one accepted input word gives, and moves the state on.
   task automatic predict_word(input logic op, input pixel_type px,
                               output bit made, output smoothed_word_type res);
      int        w;
      int        h;
      int        ic;
      pixel_type win [9];
      logic [7:0] nb;
      w    = frame_width();
      h    = frame_height();
      made = 1'b0;
      res  = '0;
      if (op == OP_DRAIN) begin
         // A drain tick only counts once the whole frame is in and something is owed.
         if (in_row >= h && held_back > 0) begin
            held_back--;
            advance_out(w);
            made          = 1'b1;
            res.pixel     = '0;
            res.frame_end = (held_back == 0);
            if (held_back == 0) begin
               in_row  = 0;
               in_col  = 0;
               out_row = 0;
               out_col = 0;
            end
         end
      end else if (in_row < h) begin
         ic = (in_col < MAX_WIDTH) ? in_col : 0;
         for (int k = 0; k < 6; k++) win[k] = past_cols[k];
         win[6] = upper_row[ic];
         win[7] = middle_row[ic];
         win[8] = px;
         upper_row[ic]  = middle_row[ic];
         middle_row[ic] = px;
         for (int k = 0; k < 6; k++) past_cols[k] = win[k+3];
         if (held_back >= w + 1) begin
            nb = {win[8] != 8'd0, win[5] != 8'd0, win[2] != 8'd0, win[7] != 8'd0,
                  win[1] != 8'd0, win[6] != 8'd0, win[3] != 8'd0, win[0] != 8'd0};
            res.pixel     = near_border(out_row, out_col, w, h) ? 8'd0
                                                                : apply_templates(nb, win[4]);
            res.frame_end = 1'b0;
            advance_out(w);
            made = 1'b1;
         end else begin
            held_back++;
         end
         in_col++;
         if (in_col >= w) begin
            in_col = 0;
            in_row++;
         end
      end
   endtask

   // Register writes, then result comparison, then prediction for the new input word.
   always @(posedge clock) begin : watch
      smoothed_word_type want;
      bit                made;
      if (reset) begin
         clear_model();
         owed_count <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_WIDTH:  width_reg  = csr_wdata[WIDTH_REG_W-1:0];
               CSR_HEIGHT: height_reg = csr_wdata[HEIGHT_REG_W-1:0];
               default: begin
               end
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (owed_q.size() == 0) begin
               report_fault($sformatf("word %0d / end %0b arrived with nothing owed",
                                      rsp_out_pixel, rsp_frame_end));
            end else begin
               want = owed_q.pop_front();
               if (rsp_out_pixel !== want.pixel)
                  report_fault($sformatf("out_pixel %0d, predicted %0d",
                                         rsp_out_pixel, want.pixel));
               if (rsp_frame_end !== want.frame_end)
                  report_fault($sformatf("frame_end %0b, predicted %0b",
                                         rsp_frame_end, want.frame_end));
            end
         end
         if (req_valid && req_ready) begin
            predict_word(req_op, req_pixel_value, made, want);
            if (made) owed_q.push_back(want);
         end
         owed_count <= owed_q.size();
      end
   end

endmodule

// File: test/tb_binary_template_smoother_3x3.sv
module tb_binary_template_smoother_3x3;

   import bts_pkg::*;

   localparam int MAX_WIDTH     = 1024;
   localparam int CYCLE_LIMIT   = 8000000;
   localparam int SETTLE_CYCLES = 8;
   localparam int RANDOM_ITEMS  = 750;

   logic                 clock;
   logic                 reset           = 1'b1;
   logic                 req_valid       = 1'b0;
   logic                 req_ready;
   logic                 req_op          = OP_PIXEL;
   pixel_type            req_pixel_value = '0;
   logic                 rsp_valid;
   logic                 rsp_ready       = 1'b0;
   pixel_type            rsp_out_pixel;
   logic                 rsp_frame_end;
   logic                 csr_valid       = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index       = CSR_WIDTH;
   logic [CFG_W-1:0]     csr_wdata       = '0;

   int mismatches;
   int owed_count;
   int cycles      = 0;
   int fed_items   = 0;
   bit src_steady  = 1'b0;

   // Result side back-pressure state.
   int sink_stall     = 0;
   int sink_mode_left = 0;
   bit sink_steady    = 1'b0;
   int sink_roll;

   binary_template_smoother_3x3 #(
      .MAX_WIDTH(MAX_WIDTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_op(req_op),
      .req_pixel_value(req_pixel_value),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_out_pixel(rsp_out_pixel),
      .rsp_frame_end(rsp_frame_end),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   smoother_checker #(
      .MAX_WIDTH(MAX_WIDTH)
   ) smoother_check (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_op(req_op),
      .req_pixel_value(req_pixel_value),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_out_pixel(rsp_out_pixel),
      .rsp_frame_end(rsp_frame_end),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .mismatches(mismatches),
      .owed_count(owed_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Run guard: a hung block ends the run as a failure.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("binary_template_smoother_3x3: mismatch");
         $finish;
      end
   end

   // The receiver alternates between steady stretches and random stalls, mostly short.
   always @(posedge clock) begin
      if (sink_mode_left == 0) begin
         sink_mode_left <= $urandom_range(50, 400);
         sink_steady    <= ($urandom_range(0, 3) == 0);
      end else begin
         sink_mode_left <= sink_mode_left - 1;
      end
      if (sink_stall > 0) begin
         rsp_ready  <= 1'b0;
         sink_stall <= sink_stall - 1;
      end else if (sink_steady) begin
         rsp_ready <= 1'b1;
      end else begin
         sink_roll = $urandom_range(0, 99);
         if (sink_roll < 70) begin
            rsp_ready <= 1'b1;
         end else if (sink_roll < 95) begin
            rsp_ready  <= 1'b0;
            sink_stall <= $urandom_range(0, 2);
         end else begin
            rsp_ready  <= 1'b0;
            sink_stall <= $urandom_range(10, 40);
         end
      end
   end

   function automatic int pick_gap();
      int roll;
      if (src_steady) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 65) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Mostly binary content so that the templates fire, with some grey bytes.
   function automatic pixel_type pick_pixel(input int density);
      int roll;
      if ($urandom_range(0, 99) >= density) return 8'd0;
      roll = $urandom_range(0, 9);
      if (roll < 4) return 8'd1;
      if (roll < 7) return 8'hFF;
      return pixel_type'($urandom_range(1, 255));
   endfunction

   // Width value with the occasional stray bit above the register width.
   function automatic logic [CFG_W-1:0] random_width();
      logic [CFG_W-1:0] wv;
      wv = CFG_W'($urandom_range(0, 20));
      if ($urandom_range(0, 7) == 0) wv = wv | CFG_W'($urandom_range(1, 3) << WIDTH_REG_W);
      return wv;
   endfunction

   // Offers one input word after a random gap and holds it until it is taken.
   task automatic send_word(input logic op, input pixel_type px);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_op          <= op;
      req_pixel_value <= px;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Stops sending and waits until every owed word has come, plus the output latency.
   task automatic wait_quiet();
      req_valid <= 1'b0;
      @(posedge clock);
      while (owed_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_frame_size(input logic [CFG_W-1:0] wv, input logic [CFG_W-1:0] hv);
      csr_valid <= 1'b1;
      csr_index <= CSR_WIDTH;
      csr_wdata <= wv;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_index <= CSR_HEIGHT;
      csr_wdata <= hv;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // One whole frame: size set while idle, pixels with stray drain ticks, then the drain
   // with stray pixels that the block must ignore.
   task automatic run_frame(input logic [CFG_W-1:0] wv, input logic [CFG_W-1:0] hv,
                            input bit steady, input bit pause_midway);
      int ew;
      int eh;
      int total;
      int density;
      wait_quiet();
      write_frame_size(wv, hv);
      src_steady = steady;
      ew = wv[WIDTH_REG_W-1:0];
      if (ew < MIN_DIM) ew = MIN_DIM;
      if (ew > MAX_WIDTH) ew = MAX_WIDTH;
      eh = hv[HEIGHT_REG_W-1:0];
      if (eh < MIN_DIM) eh = MIN_DIM;
      total   = ew * eh;
      density = $urandom_range(15, 85);
      for (int i = 0; i < total; i++) begin
         if ($urandom_range(0, 99) < 3) send_word(OP_DRAIN, pixel_type'($urandom));
         if (pause_midway && i == total / 2) wait_quiet();
         send_word(OP_PIXEL, pick_pixel(density));
      end
      for (int k = 0; k <= ew; k++) begin
         if ($urandom_range(0, 99) < 5) send_word(OP_PIXEL, pick_pixel(50));
         send_word(OP_DRAIN, pixel_type'($urandom));
      end
      fed_items += total + ew + 1;
   endtask

   initial begin
      pixel_type px;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed frame: sizes below the minimum, a cross around the single inner pixel,
      // a drain tick before the frame is in and a pixel after it.
      write_frame_size('0, '0);
      send_word(OP_DRAIN, 8'hFF);
      for (int r = 0; r < 5; r++) begin
         for (int c = 0; c < 5; c++) begin
            if (r == 2 && c == 2)
               px = 8'h80;
            else if (r == 3 && c == 2)
               px = 8'h01;
            else if (r == 0 || (r == 2 && c != 0 && c != 4) || (r == 1 && c == 2))
               px = 8'hFF;
            else
               px = 8'h00;
            send_word(OP_PIXEL, px);
         end
      end
      send_word(OP_PIXEL, 8'h7F);
      repeat (6) send_word(OP_DRAIN, 8'h00);

      // Random frames of small size; the first one pauses halfway until all is delivered.
      run_frame(13'h1809, 13'd7, 1'b0, 1'b1);
      while (fed_items < RANDOM_ITEMS)
         run_frame(random_width(), CFG_W'($urandom_range(0, 12)),
                   ($urandom_range(0, 3) == 0), 1'b0);

      wait_quiet();
      if (mismatches == 0)
         $display("binary_template_smoother_3x3: match");
      else
         $display("binary_template_smoother_3x3: mismatch");
      $finish;
   end

endmodule
